// ===== design/rdsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the radix digit string converter.
package rdsc_pkg;

	localparam int          RADIX_W       = 5;
	localparam int          DIGIT_W       = 4;
	localparam int          CHAR_W        = 8;
	localparam int          QUEUE_DEPTH   = 2;
	localparam int          QUEUE_IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int          QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_DEC_MAX = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX     = 5'd16;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0]  ASCII_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0]  CHAR_NONE     = 8'd0;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 4'd10;

	// How the back end has to treat an item.
	typedef enum logic [1:0] {
		KIND_NUM,
		KIND_ZERO,
		KIND_BAD
	} rdsc_kind_t;

	typedef struct packed {
		rdsc_kind_t              kind;
		logic [RADIX_W-1:0]      radix;
	} rdsc_tag_t;

	localparam int TAG_W = $bits(rdsc_tag_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT,
		ST_SPECIAL
	} rdsc_state_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
		if (d < DIGIT_TEN)
			return ASCII_ZERO + ext;
		return ASCII_LOWER_A + ext - {{(CHAR_W - DIGIT_W){1'b0}}, DIGIT_TEN};
	endfunction

endpackage

// ===== design/rdsc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, masks the value and classifies it for the back end.
module rdsc_front import rdsc_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [63:0]            value,
	input  logic [RADIX_W-1:0]     radix,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic [VALUE_WIDTH-1:0] push_value,
	output rdsc_tag_t              push_tag
);

	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] value_s1;
	rdsc_tag_t              tag_s1;
	logic [VALUE_WIDTH-1:0] masked;
	logic                   radix_ok;
	rdsc_tag_t              tag_in;
	logic                   accept;

	assign masked   = value[VALUE_WIDTH-1:0];
	assign radix_ok = ((radix >= RADIX_MIN) && (radix <= RADIX_DEC_MAX)) || (radix == RADIX_HEX);
	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || push_ready;

	always_comb begin
		tag_in.radix = radix;
		// A zero value prints as a single '0' even when the radix is unsupported.
		if (masked == '0)
			tag_in.kind = KIND_ZERO;
		else if (!radix_ok)
			tag_in.kind = KIND_BAD;
		else
			tag_in.kind = KIND_NUM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= masked;
			tag_s1   <= tag_in;
		end
	end

	assign push_valid = valid_s1;
	assign push_value = value_s1;
	assign push_tag   = tag_s1;

endmodule

// ===== design/rdsc_queue.sv =====
`timescale 1ns / 1ps
// Short item queue that decouples the front end from the back end.
module rdsc_queue import rdsc_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output logic [DATA_WIDTH-1:0] pop_data
);

	logic [DATA_WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_q;
	logic [QUEUE_IDX_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ===== design/rdsc_back.sv =====
`timescale 1ns / 1ps
// Back end: bit-serial binary to radix conversion and most significant first digit output.
module rdsc_back import rdsc_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  logic [VALUE_WIDTH-1:0] pop_value,
	input  rdsc_tag_t              pop_tag,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last,
	output logic                   invalid
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	rdsc_state_t            state_q, state_d;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [RADIX_W-1:0]     radix_q;
	rdsc_kind_t             kind_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          ndig_q;
	// Digit cells, index 0 is the least significant digit.
	logic [DIGIT_W-1:0]     cell_q [VALUE_WIDTH];
	logic [DIGIT_W-1:0]     cell_nxt [VALUE_WIDTH];

	logic                   ov_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   inv_q;

	logic [DIGIT_W-1:0]     half;
	logic [VALUE_WIDTH-1:0] gen;
	logic [VALUE_WIDTH-1:0] prop;
	logic [VALUE_WIDTH-1:0] a_op;
	logic [VALUE_WIDTH:0]   sum;
	logic [VALUE_WIDTH:0]   carry;
	logic [RADIX_W-1:0]     dbl;

	logic                   out_free;
	logic                   do_pop;
	logic                   conv_step;
	logic                   shift_up;
	logic                   load_out;
	logic [CHAR_W-1:0]      load_char;
	logic                   load_last;
	logic                   load_inv;

	// Doubling a digit and adding the carry from below overflows the radix when the digit
	// is at least half the radix; for an odd radix the digit equal to the lower half
	// overflows only if a carry arrives, which makes the carries an ordinary adder chain.
	assign half = radix_q[RADIX_W-1:1];

	always_comb begin
		for (int i = 0; i < VALUE_WIDTH; i++) begin
			gen[i]  = radix_q[0] ? (cell_q[i] > half) : (cell_q[i] >= half);
			prop[i] = radix_q[0] && (cell_q[i] == half);
		end
	end

	assign a_op = gen | prop;
	assign sum  = {1'b0, a_op} + {1'b0, gen} + {{VALUE_WIDTH{1'b0}}, val_q[VALUE_WIDTH-1]};

	always_comb begin
		for (int i = 0; i < VALUE_WIDTH; i++)
			carry[i] = sum[i] ^ a_op[i] ^ gen[i];
		carry[VALUE_WIDTH] = sum[VALUE_WIDTH];
	end

	always_comb begin
		for (int i = 0; i < VALUE_WIDTH; i++) begin
			dbl         = {cell_q[i], carry[i]} - (carry[i+1] ? radix_q : '0);
			cell_nxt[i] = dbl[DIGIT_W-1:0];
		end
	end

	assign out_free  = !ov_q || out_ready;
	assign pop_ready = (state_q == ST_IDLE);
	assign do_pop    = pop_valid && pop_ready;

	always_comb begin
		state_d   = state_q;
		conv_step = 1'b0;
		shift_up  = 1'b0;
		load_out  = 1'b0;
		load_char = digit_to_ascii(cell_q[VALUE_WIDTH-1]);
		load_last = (cnt_q == CW'(1));
		load_inv  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid)
					state_d = (pop_tag.kind == KIND_NUM) ? ST_CONV : ST_SPECIAL;
			end
			ST_CONV: begin
				conv_step = 1'b1;
				if (cnt_q == CW'(1))
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// Cells above the digit count hold leading zeros and are shifted out silently.
				if (cnt_q > ndig_q) begin
					shift_up = 1'b1;
				end else if (out_free) begin
					shift_up = 1'b1;
					load_out = 1'b1;
					if (cnt_q == CW'(1))
						state_d = ST_IDLE;
				end
			end
			ST_SPECIAL: begin
				load_char = (kind_q == KIND_ZERO) ? ASCII_ZERO : CHAR_NONE;
				load_last = 1'b1;
				load_inv  = (kind_q == KIND_BAD);
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ndig_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_pop) begin
				cnt_q  <= CW'(VALUE_WIDTH);
				ndig_q <= '0;
			end else if (conv_step) begin
				cnt_q  <= (cnt_q == CW'(1)) ? CW'(VALUE_WIDTH) : cnt_q - 1'b1;
				ndig_q <= ndig_q + CW'(carry[ndig_q]);
			end else if (shift_up) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_out)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			val_q   <= pop_value;
			radix_q <= pop_tag.radix;
			kind_q  <= pop_tag.kind;
			for (int i = 0; i < VALUE_WIDTH; i++)
				cell_q[i] <= '0;
		end else if (conv_step) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			for (int i = 0; i < VALUE_WIDTH; i++)
				cell_q[i] <= cell_nxt[i];
		end else if (shift_up) begin
			cell_q[0] <= '0;
			for (int i = 1; i < VALUE_WIDTH; i++)
				cell_q[i] <= cell_q[i-1];
		end
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
			inv_q  <= load_inv;
		end
	end

	assign out_valid  = ov_q;
	assign digit_char = char_q;
	assign last       = last_q;
	assign invalid    = inv_q;

endmodule

// ===== design/radix_digit_string_converter_core.sv =====
`timescale 1ns / 1ps
// Top level of the radix digit string converter.
//
// Input channel (in_valid/in_ready): one item is a value and a radix. Only the low
// VALUE_WIDTH bits of the value are converted. Radixes 2 to 10 and 16 are supported.
// Output channel (out_valid/out_ready): one item per ASCII digit, most significant
// first, no leading zeros, last set on the final digit. Hex digits are lowercase.
// A zero value gives a single '0'; a nonzero value with an unsupported radix gives a
// single item with invalid and last set and a zero character.
// The front end registers and classifies an item and passes it through a two-entry
// queue, so up to three items can be taken while the back end is busy.
// The back end converts one bit per cycle, then shifts the digit cells out one per
// cycle, pausing while the receiver stalls; it pops a new item only after the last
// character of the current one has been loaded into the output register.
// When the receiver stalls, the digit output holds and the back end waits; the queue
// fills and then in_ready drops. Reset empties the queue and clears all control state.
module radix_digit_string_converter_core import rdsc_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        value,
	input  logic [RADIX_W-1:0] radix,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last,
	output logic               invalid
);

	localparam int QW = TAG_W + VALUE_WIDTH;

	logic                   push_valid;
	logic                   push_ready;
	logic [VALUE_WIDTH-1:0] push_value;
	rdsc_tag_t              push_tag;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [QW-1:0]          pop_data;
	rdsc_tag_t              pop_tag;
	logic [VALUE_WIDTH-1:0] pop_value;

	rdsc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.radix      (radix),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_value (push_value),
		.push_tag   (push_tag)
	);

	rdsc_queue #(.DATA_WIDTH(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_tag, push_value}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_tag   = rdsc_tag_t'(pop_data[QW-1:VALUE_WIDTH]);
	assign pop_value = pop_data[VALUE_WIDTH-1:0];

	rdsc_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_value  (pop_value),
		.pop_tag    (pop_tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last),
		.invalid    (invalid)
	);

`ifndef ASSERT_OFF
	a_invalid_single : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> last && (digit_char == CHAR_NONE))
		else $error("invalid item is not a single empty character");

	a_digit_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |->
			((digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 8'd9)) ||
			((digit_char >= ASCII_LOWER_A) && (digit_char <= ASCII_LOWER_A + 8'd5)))
		else $error("digit character out of range");

	a_pop_needs_data : assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready && !pop_valid |=> !out_valid || $past(out_valid))
		else $error("output raised without a queued item");
`endif

endmodule
